@@ design/tcrmv_pkg.sv @@
// Package for the two-channel running mean and variance unit.
// Holds the window limit, the fixed-point format and the derived datapath widths.
// No dependencies.
package tcrmv_pkg;

    localparam int MAX_SAMPLES = 255;
    localparam int FRAC_BITS   = 16;

    // Sample and result field widths
    localparam int SAMPLE_W    = 8;
    localparam int OUT_MEAN_W  = 24;
    localparam int OUT_COUNT_W = 8;
    localparam int VAR_W       = 31;
    localparam int SQ_W        = 40;

    localparam int COUNT_W = $clog2(MAX_SAMPLES + 1);
    // Mean and scaled sample: sign + sample bits + fraction bits
    localparam int MEAN_W  = SAMPLE_W + 1 + FRAC_BITS;
    localparam int DIFF_W  = MEAN_W + 1;
    // Magnitude of a deviation stays below 2^(SAMPLE_W + FRAC_BITS)
    localparam int MAG_W   = SAMPLE_W + FRAC_BITS;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int SUM_W   = ((PROD_W > SQ_W) ? PROD_W : SQ_W) + 2;
    // Bits of M2 above the variance field
    localparam int TOP_W   = SQ_W - VAR_W;
    localparam int CMP_W   = (TOP_W > COUNT_W) ? TOP_W : COUNT_W;
    localparam int ITER_W  = $clog2(SQ_W);

endpackage

@@ design/two_channel_running_mean_variance_unit.sv @@
// Two-channel running mean and sample variance (Welford update), one shared
// restoring divider under a small sequencer. Depends on tcrmv_pkg.
//
//  channel | handshake          | payload
//  --------+--------------------+------------------------------------------------
//  s_      | s_valid / s_ready  | temperature_sample, light_sample, window_end
//  m_      | m_valid / m_ready  | means, variances, sample_count, flags
//
// An accumulated sample holds s_ready low after acceptance until both channels are
// done, each running a deviation step, the shared divider (one quotient bit a
// cycle), then mean, multiply and M2 update steps. A window end then adds per
// channel a setup step, a divider pass and a store step (for a count below two or
// a saturated variance the setup step sets the field itself), then ST_OUT loads
// the result register.
// A dropped sample (count saturated) returns straight to idle, or runs the variance
// pass if it ends the window. Reset (aresetn low, synchronous) clears the window.
// A result held by a stalled m_ready blocks only the next window end.
module two_channel_running_mean_variance_unit (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic signed [tcrmv_pkg::SAMPLE_W-1:0]  s_temperature_sample,
    input  logic        [tcrmv_pkg::SAMPLE_W-1:0]  s_light_sample,
    input  logic                                   s_window_end,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [tcrmv_pkg::OUT_MEAN_W-1:0] m_temperature_mean,
    output logic        [tcrmv_pkg::OUT_MEAN_W-1:0] m_light_mean,
    output logic        [tcrmv_pkg::VAR_W-1:0]     m_temperature_variance,
    output logic        [tcrmv_pkg::VAR_W-1:0]     m_light_variance,
    output logic        [tcrmv_pkg::OUT_COUNT_W-1:0] m_sample_count,
    output logic                                   m_variance_valid,
    output logic                                   m_samples_dropped
);

    localparam int SAMPLE_W = tcrmv_pkg::SAMPLE_W;
    localparam int FRAC_W   = tcrmv_pkg::FRAC_BITS;
    localparam int COUNT_W  = tcrmv_pkg::COUNT_W;
    localparam int MEAN_W   = tcrmv_pkg::MEAN_W;
    localparam int DIFF_W   = tcrmv_pkg::DIFF_W;
    localparam int MAG_W    = tcrmv_pkg::MAG_W;
    localparam int PROD_W   = tcrmv_pkg::PROD_W;
    localparam int SUM_W    = tcrmv_pkg::SUM_W;
    localparam int SQ_W     = tcrmv_pkg::SQ_W;
    localparam int VAR_W    = tcrmv_pkg::VAR_W;
    localparam int TOP_W    = tcrmv_pkg::TOP_W;
    localparam int CMP_W    = tcrmv_pkg::CMP_W;
    localparam int ITER_W   = tcrmv_pkg::ITER_W;
    localparam int OMEAN_W  = tcrmv_pkg::OUT_MEAN_W;
    localparam int OCOUNT_W = tcrmv_pkg::OUT_COUNT_W;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIFF,
        ST_DIV,
        ST_MEAN,
        ST_MUL,
        ST_ACC,
        ST_VLOAD,
        ST_VSTORE,
        ST_OUT
    } state_t;

    state_t                     state_reg;
    logic                       ch_reg;
    logic                       var_phase_reg;
    logic                       last_reg;
    logic signed [SAMPLE_W-1:0] temp_reg;
    logic        [SAMPLE_W-1:0] light_reg;

    logic [COUNT_W-1:0]         count_reg;
    logic                       overflow_reg;
    logic signed [MEAN_W-1:0]   tmean_reg;
    logic signed [MEAN_W-1:0]   lmean_reg;
    logic [SQ_W-1:0]            tm2_reg;
    logic [SQ_W-1:0]            lm2_reg;
    logic [VAR_W-1:0]           tvar_reg;
    logic [VAR_W-1:0]           lvar_reg;

    logic signed [DIFF_W-1:0]   diff_reg;
    logic signed [DIFF_W-1:0]   diff2_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic                       neg_reg;

    // Shared divider
    logic [COUNT_W-1:0]         d_reg;
    logic [COUNT_W-1:0]         rem_reg;
    logic [SQ_W-1:0]            dvd_reg;
    logic [ITER_W-1:0]          iter_reg;

    logic                       m_valid_reg;

    logic signed [MEAN_W-1:0]   xs_cur;
    logic signed [MEAN_W-1:0]   mean_cur;
    logic [SQ_W-1:0]            m2_cur;
    logic signed [DIFF_W-1:0]   diff;
    logic signed [DIFF_W-1:0]   diff_abs;
    logic [MAG_W-1:0]           mag;
    logic [COUNT_W:0]           div_shift;
    logic [COUNT_W:0]           div_sub;
    logic                       div_ge;
    logic signed [MEAN_W-1:0]   q_ext;
    logic signed [MEAN_W-1:0]   q_signed;
    logic signed [MEAN_W-1:0]   mean_new;
    logic signed [DIFF_W-1:0]   diff2;
    logic signed [PROD_W-1:0]   inc;
    logic signed [SUM_W-1:0]    sum;
    logic [SQ_W-1:0]            m2_next;
    logic [COUNT_W-1:0]         count_m1;
    logic [CMP_W-1:0]           top_cmp;
    logic [CMP_W-1:0]           dm1_cmp;
    logic                       var_sat;

    always_comb begin
        if (ch_reg) begin
            xs_cur   = {1'b0, light_reg, {FRAC_W{1'b0}}};
            mean_cur = lmean_reg;
            m2_cur   = lm2_reg;
        end else begin
            xs_cur   = {temp_reg[SAMPLE_W-1], temp_reg, {FRAC_W{1'b0}}};
            mean_cur = tmean_reg;
            m2_cur   = tm2_reg;
        end

        diff     = DIFF_W'(xs_cur) - DIFF_W'(mean_cur);
        diff_abs = diff[DIFF_W-1] ? -diff : diff;
        mag      = diff_abs[MAG_W-1:0];

        // One restoring step: shift in the next dividend bit, subtract if it fits
        div_shift = {rem_reg, dvd_reg[SQ_W-1]};
        div_sub   = div_shift - {1'b0, d_reg};
        div_ge    = div_shift >= {1'b0, d_reg};

        // Quotient magnitude, sign restored for truncation toward zero
        q_ext    = {{(MEAN_W-MAG_W){1'b0}}, dvd_reg[MAG_W-1:0]};
        q_signed = neg_reg ? -q_ext : q_ext;
        mean_new = mean_cur + q_signed;
        diff2    = DIFF_W'(xs_cur) - DIFF_W'(mean_new);

        inc = prod_reg >>> FRAC_W;
        sum = SUM_W'(inc) + SUM_W'(signed'({1'b0, m2_cur}));
        if (sum[SUM_W-1]) begin
            m2_next = '0;
        end else if (|sum[SUM_W-2:SQ_W]) begin
            m2_next = '1;
        end else begin
            m2_next = sum[SQ_W-1:0];
        end

        // Quotient reaches 2^VAR_W exactly when the bits above VAR_W hold n-1 or more
        count_m1 = count_reg - COUNT_W'(1);
        top_cmp  = CMP_W'(m2_cur[SQ_W-1:VAR_W]);
        dm1_cmp  = CMP_W'(count_m1);
        var_sat  = top_cmp >= dm1_cmp;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            ch_reg        <= 1'b0;
            var_phase_reg <= 1'b0;
            count_reg     <= '0;
            overflow_reg  <= 1'b0;
            tmean_reg     <= '0;
            lmean_reg     <= '0;
            tm2_reg       <= '0;
            lm2_reg       <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            // ST_OUT reloads the result register on its own
            if (m_valid_reg && m_ready && state_reg != ST_OUT) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        temp_reg      <= s_temperature_sample;
                        light_reg     <= s_light_sample;
                        last_reg      <= s_window_end;
                        ch_reg        <= 1'b0;
                        if (count_reg >= COUNT_W'(tcrmv_pkg::MAX_SAMPLES)) begin
                            // Drop the sample, still close the window if asked
                            overflow_reg <= 1'b1;
                            if (s_window_end) begin
                                var_phase_reg <= 1'b1;
                                state_reg     <= ST_VLOAD;
                            end
                        end else begin
                            count_reg <= count_reg + COUNT_W'(1);
                            state_reg <= ST_DIFF;
                        end
                    end
                end

                ST_DIFF: begin
                    diff_reg  <= diff;
                    neg_reg   <= diff[DIFF_W-1];
                    d_reg     <= count_reg;
                    rem_reg   <= '0;
                    dvd_reg   <= {mag, {(SQ_W-MAG_W){1'b0}}};
                    iter_reg  <= ITER_W'(MAG_W - 1);
                    state_reg <= ST_DIV;
                end

                ST_DIV: begin
                    rem_reg  <= div_ge ? div_sub[COUNT_W-1:0] : div_shift[COUNT_W-1:0];
                    dvd_reg  <= {dvd_reg[SQ_W-2:0], div_ge};
                    iter_reg <= iter_reg - ITER_W'(1);
                    if (iter_reg == '0) begin
                        state_reg <= var_phase_reg ? ST_VSTORE : ST_MEAN;
                    end
                end

                ST_MEAN: begin
                    if (ch_reg) begin
                        lmean_reg <= mean_new;
                    end else begin
                        tmean_reg <= mean_new;
                    end
                    diff2_reg <= diff2;
                    state_reg <= ST_MUL;
                end

                ST_MUL: begin
                    prod_reg  <= diff_reg * diff2_reg;
                    state_reg <= ST_ACC;
                end

                ST_ACC: begin
                    if (ch_reg) begin
                        lm2_reg <= m2_next;
                    end else begin
                        tm2_reg <= m2_next;
                    end
                    if (!ch_reg) begin
                        ch_reg    <= 1'b1;
                        state_reg <= ST_DIFF;
                    end else if (last_reg) begin
                        ch_reg        <= 1'b0;
                        var_phase_reg <= 1'b1;
                        state_reg     <= ST_VLOAD;
                    end else begin
                        state_reg <= ST_IDLE;
                    end
                end

                ST_VLOAD: begin
                    if (count_reg < COUNT_W'(2) || var_sat) begin
                        if (ch_reg) begin
                            lvar_reg <= (count_reg < COUNT_W'(2)) ? '0 : '1;
                        end else begin
                            tvar_reg <= (count_reg < COUNT_W'(2)) ? '0 : '1;
                        end
                        if (!ch_reg) begin
                            ch_reg <= 1'b1;
                        end else begin
                            state_reg <= ST_OUT;
                        end
                    end else begin
                        d_reg     <= count_m1;
                        rem_reg   <= top_cmp[COUNT_W-1:0];
                        dvd_reg   <= {m2_cur[VAR_W-1:0], {TOP_W{1'b0}}};
                        iter_reg  <= ITER_W'(VAR_W - 1);
                        state_reg <= ST_DIV;
                    end
                end

                ST_VSTORE: begin
                    if (ch_reg) begin
                        lvar_reg  <= dvd_reg[VAR_W-1:0];
                        state_reg <= ST_OUT;
                    end else begin
                        tvar_reg  <= dvd_reg[VAR_W-1:0];
                        ch_reg    <= 1'b1;
                        state_reg <= ST_VLOAD;
                    end
                end

                ST_OUT: begin
                    // Hold until the previous result transaction has gone
                    if (!m_valid_reg || m_ready) begin
                        m_temperature_mean     <= OMEAN_W'(tmean_reg);
                        m_light_mean           <= OMEAN_W'(lmean_reg);
                        m_temperature_variance <= tvar_reg;
                        m_light_variance       <= lvar_reg;
                        m_sample_count         <= OCOUNT_W'(count_reg);
                        m_variance_valid       <= count_reg >= COUNT_W'(2);
                        m_samples_dropped      <= overflow_reg;
                        m_valid_reg            <= 1'b1;
                        count_reg              <= '0;
                        overflow_reg           <= 1'b0;
                        tmean_reg              <= '0;
                        lmean_reg              <= '0;
                        tm2_reg                <= '0;
                        lm2_reg                <= '0;
                        ch_reg                 <= 1'b0;
                        var_phase_reg          <= 1'b0;
                        state_reg              <= ST_IDLE;
                    end
                end

                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

endmodule
